// File: sv/tlsed_pkg.sv
package tlsed_pkg;

  localparam int DIV_W  = 8;
  localparam int THR_W  = 16;
  localparam int OUT_W  = 16;
  localparam int EDGE_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DIVISOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 2'd1;

  localparam logic [EDGE_W-1:0] EDGE_NONE    = 2'd0;
  localparam logic [EDGE_W-1:0] EDGE_PRESS   = 2'd1;
  localparam logic [EDGE_W-1:0] EDGE_RELEASE = 2'd2;

  localparam logic [DIV_W-1:0] DIVISOR_RST   = 8'd3;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd40;
  localparam int LEVEL_NOW_RST    = 65;
  localparam int LEVEL_BEFORE_RST = 54;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic div_start;
    logic level_load;
    logic out_load;
  } seq_ctl_t;

endpackage

// File: sv/touch_level_smoother_edge_detect.sv
// An accepted item starts the divider; ST_DIVIDE updates the level on done,
//   and ST_FINISH loads the output register once it is free. The restoring
//   divider produces one quotient bit per cycle; in_stall is high outside ST_IDLE.
// The output register lets the next item in while a result waits.
// Reset (rst_n low, synchronous): divisor 3, threshold 40, level 65,
//   previous level 54, touched flag clear, no result pending.
module touch_level_smoother_edge_detect #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [tlsed_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tlsed_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [SAMPLE_WIDTH-1:0]              in_raw_sample,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [tlsed_pkg::OUT_W-1:0]          out_smoothed_level,
  output logic                                 out_touched,
  output logic [tlsed_pkg::EDGE_W-1:0]         out_edge_kind
);

  localparam int SW = SAMPLE_WIDTH;
  // Compare width: wide enough for both the level and the 16-bit threshold.
  localparam int CW = (SW > tlsed_pkg::THR_W) ? SW : tlsed_pkg::THR_W;

  // Configuration registers
  logic [tlsed_pkg::DIV_W-1:0] divisor_r;
  logic [tlsed_pkg::THR_W-1:0] threshold_r;

  // Smoother state
  logic [SW-1:0] level_r, level_nxt;
  logic [SW-1:0] before_r;
  logic          flag_r, flag_nxt;
  logic          up_r;

  // Sequencer
  tlsed_pkg::state_t   state_r, state_nxt;
  tlsed_pkg::seq_ctl_t ctl;

  // Output register
  logic                         out_valid_r;
  logic [tlsed_pkg::OUT_W-1:0]  out_level_r;
  logic                         out_touched_r;
  logic [tlsed_pkg::EDGE_W-1:0] out_edge_r;

  logic                         in_accept;
  logic                         out_free;
  logic                         div_done;
  logic [SW-1:0]                quotient;
  logic [SW-1:0]                diff;
  logic                         sample_up;
  logic [tlsed_pkg::DIV_W-1:0]  div_eff;
  logic [CW-1:0]                thr_ext, prev_ext, now_ext;
  logic [tlsed_pkg::EDGE_W-1:0] edge_nxt;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != tlsed_pkg::ST_IDLE);

  // A zero divisor acts as one: the level jumps straight to the sample.
  assign div_eff = (divisor_r == '0) ? tlsed_pkg::DIV_W'(1) : divisor_r;

  // Magnitude of the step, taken in the accept cycle.
  always_comb begin
    sample_up = (in_raw_sample > level_r);
    diff      = sample_up ? (in_raw_sample - level_r) : (level_r - in_raw_sample);
  end

  tlsed_div #(
    .WIDTH(SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (diff),
    .divisor  (div_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlsed_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tlsed_pkg::ST_DIVIDE;
      end
      tlsed_pkg::ST_DIVIDE: begin
        if (div_done) state_nxt = tlsed_pkg::ST_FINISH;
      end
      tlsed_pkg::ST_FINISH: begin
        if (out_free) state_nxt = tlsed_pkg::ST_IDLE;
      end
      default: state_nxt = tlsed_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    ctl = '0;
    unique case (state_r)
      tlsed_pkg::ST_IDLE:   ctl.div_start  = in_valid;
      tlsed_pkg::ST_DIVIDE: ctl.level_load = div_done;
      tlsed_pkg::ST_FINISH: ctl.out_load   = out_free;
      default: ctl = '0;
    endcase
  end

  // Quotient never exceeds the difference, so no wrap here.
  assign level_nxt = up_r ? (level_r + quotient) : (level_r - quotient);

  // Crossing detect: previous step's level against the new one.
  always_comb begin
    thr_ext  = CW'(threshold_r);
    prev_ext = CW'(before_r);
    now_ext  = CW'(level_r);
    edge_nxt = tlsed_pkg::EDGE_NONE;
    flag_nxt = flag_r;
    if (prev_ext > thr_ext && now_ext < thr_ext) begin
      edge_nxt = tlsed_pkg::EDGE_PRESS;
      flag_nxt = 1'b1;
    end else if (prev_ext < thr_ext && now_ext > thr_ext) begin
      edge_nxt = tlsed_pkg::EDGE_RELEASE;
      flag_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlsed_pkg::ST_IDLE;
      divisor_r   <= tlsed_pkg::DIVISOR_RST;
      threshold_r <= tlsed_pkg::THRESHOLD_RST;
      level_r     <= SW'(tlsed_pkg::LEVEL_NOW_RST);
      before_r    <= SW'(tlsed_pkg::LEVEL_BEFORE_RST);
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          tlsed_pkg::CFG_IDX_DIVISOR:
            divisor_r <= cfg_wdata[tlsed_pkg::DIV_W-1:0];
          tlsed_pkg::CFG_IDX_THRESHOLD:
            threshold_r <= cfg_wdata[tlsed_pkg::THR_W-1:0];
          default: ;  // unknown index: ignored
        endcase
      end
      if (ctl.level_load) level_r <= level_nxt;
      if (ctl.out_load) begin
        before_r <= level_r;
        flag_r   <= flag_nxt;
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) up_r <= sample_up;
    if (ctl.out_load) begin
      out_level_r   <= tlsed_pkg::OUT_W'(now_ext);
      out_touched_r <= flag_nxt;
      out_edge_r    <= edge_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_smoothed_level = out_level_r;
  assign out_touched        = out_touched_r;
  assign out_edge_kind      = out_edge_r;

endmodule

// File: sv/tlsed_div.sv
// Restoring divider, one quotient bit per cycle.
module tlsed_div #(
  parameter int WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [WIDTH-1:0]             dividend,
  input  logic [tlsed_pkg::DIV_W-1:0]  divisor,
  output logic                         done,
  output logic [WIDTH-1:0]             quotient
);

  localparam int CNT_W = $clog2(WIDTH + 1);
  localparam int DW    = tlsed_pkg::DIV_W;

  logic [DW-1:0]    rem_r, rem_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]    dvsr_r, dvsr_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DW:0]   shifted;
  logic [DW-1:0] trial;
  logic          fits;

  // Remainder stays below the divisor, so the trial difference fits in DW bits.
  always_comb begin
    shifted = {rem_r, quo_r[WIDTH-1]};
    fits    = (shifted >= {1'b0, dvsr_r});
    trial   = DW'(shifted - {1'b0, dvsr_r});
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    dvsr_nxt = dvsr_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_W'(WIDTH);
      dvsr_nxt = divisor;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? trial : shifted[DW-1:0];
      quo_nxt = {quo_r[WIDTH-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: sv/tlsed_chk.sv
module tlsed_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [tlsed_pkg::OUT_W-1:0]      out_smoothed_level,
  input logic                             out_touched,
  input logic [tlsed_pkg::EDGE_W-1:0]     out_edge_kind
);

  // One item at a time: busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // An accepted item cannot produce a result in the very next cycle.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  a_press_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_edge_kind == tlsed_pkg::EDGE_PRESS |-> out_touched)
    else $error("press edge without touched flag");

  a_release_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_edge_kind == tlsed_pkg::EDGE_RELEASE |-> !out_touched)
    else $error("release edge with touched flag");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_smoothed_level)
      && $stable(out_touched) && $stable(out_edge_kind))
    else $error("stalled result changed");

endmodule

bind touch_level_smoother_edge_detect tlsed_chk u_tlsed_chk (.*);
